// File: rtl/psgc_pkg.sv
package psgc_pkg;

  localparam int NUM_DIMS  = 3;
  localparam int DIM_W     = 2;
  localparam int EXT_W     = 11;
  localparam int ELEM_W    = 5;
  localparam int DIMS_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 11;
  localparam int OFS_W     = 34;
  localparam int LEN_W     = 35;
  localparam int DIV_STEPS = EXT_W;
  localparam int STEP_W    = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INTO_GRID = 3'd5;

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_CALC1,
    OP_CALC2,
    OP_CALC3,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [DIM_W-1:0] dim;
  } dp_cmd_t;

  typedef struct packed {
    logic req_busy;
    logic out_stall;
  } dp_status_t;

endpackage

// File: rtl/psgc_ctrl.sv
module psgc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  action_i,
  output logic                  in_ready_o,
  input  psgc_pkg::dp_status_t  status_i,
  output psgc_pkg::dp_cmd_t     cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DLOAD  = 3'd1;
  localparam logic [2:0] S_DSTEP  = 3'd2;
  localparam logic [2:0] S_DSTORE = 3'd3;
  localparam logic [2:0] S_CALC2  = 3'd4;
  localparam logic [2:0] S_CALC3  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]                      state_q, state_d;
  logic [psgc_pkg::DIM_W-1:0]      dim_q, dim_d;
  logic [psgc_pkg::STEP_W-1:0]     step_q, step_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    dim_d     = dim_q;
    step_d    = step_q;
    cmd_o.op  = psgc_pkg::OP_NONE;
    cmd_o.dim = dim_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (action_i == psgc_pkg::ACT_START) begin
            cmd_o.op = psgc_pkg::OP_START;
            dim_d    = '0;
            state_d  = S_DLOAD;
          end else if (status_i.req_busy) begin
            cmd_o.op = psgc_pkg::OP_CALC1;
            state_d  = S_CALC2;
          end
        end
      end
      S_DLOAD: begin
        cmd_o.op = psgc_pkg::OP_DIV_LOAD;
        step_d   = '0;
        state_d  = S_DSTEP;
      end
      S_DSTEP: begin
        cmd_o.op = psgc_pkg::OP_DIV_STEP;
        step_d   = step_q + 1'b1;
        if (step_q == psgc_pkg::STEP_W'(psgc_pkg::DIV_STEPS - 1)) begin
          state_d = S_DSTORE;
        end
      end
      S_DSTORE: begin
        cmd_o.op = psgc_pkg::OP_DIV_STORE;
        if (dim_q == psgc_pkg::DIM_W'(psgc_pkg::NUM_DIMS - 1)) begin
          state_d = S_IDLE;
        end else begin
          dim_d   = dim_q + 1'b1;
          state_d = S_DLOAD;
        end
      end
      S_CALC2: begin
        cmd_o.op = psgc_pkg::OP_CALC2;
        state_d  = S_CALC3;
      end
      S_CALC3: begin
        cmd_o.op = psgc_pkg::OP_CALC3;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (!status_i.out_stall) begin
          cmd_o.op = psgc_pkg::OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dim_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      dim_q   <= dim_d;
      step_q  <= step_d;
    end
  end

endmodule

// File: rtl/psgc_dp.sv
module psgc_dp #(
  parameter int MAX_EXTENT     = 1024,
  parameter int MAX_ELEM_BYTES = 16,
  parameter int MAX_DIMS       = 3
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  psgc_pkg::dp_cmd_t                      cmd_i,
  output psgc_pkg::dp_status_t                   status_o,
  input  logic                                   cfg_valid_i,
  input  logic [psgc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [psgc_pkg::CFG_DAT_W-1:0]         cfg_data_i,
  input  logic signed [psgc_pkg::EXT_W-1:0]      off_x_i,
  input  logic signed [psgc_pkg::EXT_W-1:0]      off_y_i,
  input  logic signed [psgc_pkg::EXT_W-1:0]      off_z_i,
  input  logic [psgc_pkg::EXT_W-1:0]             size_x_i,
  input  logic [psgc_pkg::EXT_W-1:0]             size_y_i,
  input  logic [psgc_pkg::EXT_W-1:0]             size_z_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [psgc_pkg::OFS_W-1:0]             grid_byte_offset_o,
  output logic [psgc_pkg::OFS_W-1:0]             buffer_byte_offset_o,
  output logic [psgc_pkg::LEN_W-1:0]             length_bytes_o,
  output logic                                   write_to_grid_o,
  output logic                                   last_o
);

  localparam int EW    = psgc_pkg::EXT_W;
  localparam int ND    = psgc_pkg::NUM_DIMS;
  localparam int M1_W  = 2 * EW;
  localparam int M2_W  = M1_W + 1 + EW;
  localparam int G_W   = M2_W + 1 + psgc_pkg::ELEM_W;
  localparam int LB1_W = 2 * EW;
  localparam int LB2_W = 3 * EW;
  localparam int LF_W  = LB2_W + psgc_pkg::ELEM_W;

  localparam int ExtMaxRepr  = (1 << EW) - 1;
  localparam int ElemMaxRepr = (1 << psgc_pkg::ELEM_W) - 1;
  localparam int DimsMaxRepr = (1 << psgc_pkg::DIMS_W) - 1;
  localparam logic [EW-1:0] ExtClamp =
    EW'((MAX_EXTENT > ExtMaxRepr) ? ExtMaxRepr : MAX_EXTENT);
  localparam logic [psgc_pkg::ELEM_W-1:0] ElemClamp =
    psgc_pkg::ELEM_W'((MAX_ELEM_BYTES > ElemMaxRepr) ? ElemMaxRepr : MAX_ELEM_BYTES);
  localparam logic [psgc_pkg::DIMS_W-1:0] DimsClamp =
    psgc_pkg::DIMS_W'((MAX_DIMS > DimsMaxRepr) ? DimsMaxRepr : MAX_DIMS);

  // configuration registers
  logic [EW-1:0]                   reg_grid_q [ND];
  logic [psgc_pkg::ELEM_W-1:0]     reg_elem_q;
  logic [psgc_pkg::DIMS_W-1:0]     reg_dims_q;
  logic                            reg_into_q;

  // latched request
  logic                            req_busy_q;
  logic                            contig_q;
  logic [EW-1:0]                   lat_grid_q [ND];
  logic [psgc_pkg::ELEM_W-1:0]     lat_elem_q;
  logic                            lat_into_q;
  logic [EW-1:0]                   size_q [ND];
  logic                            off_neg_q [ND];
  logic [EW-1:0]                   off_mag_q [ND];
  logic [EW-1:0]                   saved_off_q [ND];

  // row walk
  logic [EW-1:0]                   row_y_q, row_z_q;
  logic [EW-1:0]                   cur_y_q, cur_z_q;
  logic                            second_q;
  logic [EW-1:0]                   x_left_q;
  logic [psgc_pkg::LEN_W-1:0]      buf_pos_q;

  // remainder unit
  logic [EW-1:0]                   div_rem_q, div_num_q;
  logic [EW:0]                     div_sh, div_g;
  logic [EW-1:0]                   div_rem_next, div_fix;

  // offset / length chain
  logic [M1_W-1:0]                 m1_q;
  logic [M2_W-1:0]                 m2_q;
  logic [EW-1:0]                   yy_q, xx_q;
  logic [LB1_W-1:0]                lb1_q;
  logic [LB2_W-1:0]                lb2_q;
  logic [psgc_pkg::OFS_W-1:0]      gofs_q;
  logic [psgc_pkg::LEN_W-1:0]      len_q;
  logic                            last_q, second_next_q, row_end_y_q;
  logic [EW-1:0]                   xl_next_q;

  // output register
  logic                            out_valid_q;
  logic [psgc_pkg::OFS_W-1:0]      out_gofs_q, out_bofs_q;
  logic [psgc_pkg::LEN_W-1:0]      out_len_q;
  logic                            out_into_q, out_last_q;

  // start-time values
  logic [EW-1:0]                   off_in [ND];
  logic [EW-1:0]                   size_in [ND];
  logic [psgc_pkg::DIMS_W-1:0]     dims_c;
  logic [psgc_pkg::ELEM_W-1:0]     elem_c;
  logic [EW-1:0]                   st_grid [ND];
  logic [EW-1:0]                   st_size [ND];
  logic                            st_neg [ND];
  logic [EW-1:0]                   st_mag [ND];
  logic                            st_contig, st_empty;

  // calc1 values
  logic [EW-1:0]                   c_yy, c_zz, c_xx, c_piece, c_xl_next, c_avail;
  logic                            c_second_next, c_row_end_y, c_row_end_z;
  logic [EW:0]                     cur_y_inc, cur_z_inc;
  logic [psgc_pkg::LEN_W-1:0]      buf_pos_next;
  logic [G_W-1:0]                  gofs_full;
  logic [LF_W-1:0]                 len_full;

  assign off_in[0]  = off_x_i;
  assign off_in[1]  = off_y_i;
  assign off_in[2]  = off_z_i;
  assign size_in[0] = size_x_i;
  assign size_in[1] = size_y_i;
  assign size_in[2] = size_z_i;

  always_comb begin
    dims_c = (reg_dims_q == '0) ? psgc_pkg::DIMS_W'(1) :
             ((reg_dims_q > DimsClamp) ? DimsClamp : reg_dims_q);
    elem_c = (reg_elem_q == '0) ? psgc_pkg::ELEM_W'(1) :
             ((reg_elem_q > ElemClamp) ? ElemClamp : reg_elem_q);
    st_contig = 1'b1;
    st_empty  = 1'b0;
    for (int i = 0; i < ND; i++) begin
      if (i < int'(dims_c)) begin
        st_grid[i] = (reg_grid_q[i] == '0) ? EW'(1) :
                     ((reg_grid_q[i] > ExtClamp) ? ExtClamp : reg_grid_q[i]);
        st_size[i] = (size_in[i] > ExtClamp) ? ExtClamp : size_in[i];
        st_neg[i]  = off_in[i][EW-1];
        st_mag[i]  = st_neg[i] ? (~off_in[i] + 1'b1) : off_in[i];
        if (size_in[i] == '0) begin
          st_empty = 1'b1;
        end
        if ((i + 1 < int'(dims_c)) && ((off_in[i] != '0) || (st_size[i] != st_grid[i]))) begin
          st_contig = 1'b0;
        end
      end else begin
        st_grid[i] = EW'(1);
        st_size[i] = EW'(1);
        st_neg[i]  = 1'b0;
        st_mag[i]  = '0;
      end
    end
  end

  // restoring division step; the partial remainder stays below the extent
  assign div_sh       = {div_rem_q, div_num_q[EW-1]};
  assign div_g        = {1'b0, lat_grid_q[cmd_i.dim]};
  assign div_rem_next = (div_sh >= div_g) ? EW'(div_sh - div_g) : div_sh[EW-1:0];
  assign div_fix      = (off_neg_q[cmd_i.dim] && (div_rem_q != '0)) ?
                        (lat_grid_q[cmd_i.dim] - div_rem_q) : div_rem_q;

  always_comb begin
    c_avail = lat_grid_q[0] - saved_off_q[0];
    if (contig_q) begin
      c_yy = saved_off_q[1];
      c_zz = saved_off_q[2];
      c_xx = saved_off_q[0];
    end else begin
      c_yy = cur_y_q;
      c_zz = cur_z_q;
      c_xx = second_q ? '0 : saved_off_q[0];
    end
    if (!second_q) begin
      c_piece   = (c_avail > size_q[0]) ? size_q[0] : c_avail;
      c_xl_next = size_q[0] - c_piece;
    end else begin
      c_piece   = (x_left_q < lat_grid_q[0]) ? x_left_q : lat_grid_q[0];
      c_xl_next = x_left_q - c_piece;
    end
    c_second_next = (c_xl_next != '0);
    c_row_end_y   = (({1'b0, row_y_q} + 1'b1) >= {1'b0, size_q[1]});
    c_row_end_z   = (({1'b0, row_z_q} + 1'b1) >= {1'b0, size_q[2]});
  end

  assign cur_y_inc    = {1'b0, cur_y_q} + 1'b1;
  assign cur_z_inc    = {1'b0, cur_z_q} + 1'b1;
  assign buf_pos_next = buf_pos_q + len_q;
  assign gofs_full    = G_W'(G_W'({1'b0, m2_q}) + G_W'(xx_q)) * G_W'(lat_elem_q);
  assign len_full     = LF_W'(lb2_q) * LF_W'(lat_elem_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_grid_q[0] <= EW'(1024);
      reg_grid_q[1] <= EW'(1024);
      reg_grid_q[2] <= EW'(1024);
      reg_elem_q    <= psgc_pkg::ELEM_W'(4);
      reg_dims_q    <= psgc_pkg::DIMS_W'(3);
      reg_into_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        psgc_pkg::CFG_GRID_X:    reg_grid_q[0] <= cfg_data_i[EW-1:0];
        psgc_pkg::CFG_GRID_Y:    reg_grid_q[1] <= cfg_data_i[EW-1:0];
        psgc_pkg::CFG_GRID_Z:    reg_grid_q[2] <= cfg_data_i[EW-1:0];
        psgc_pkg::CFG_ELEM:      reg_elem_q    <= cfg_data_i[psgc_pkg::ELEM_W-1:0];
        psgc_pkg::CFG_DIMS:      reg_dims_q    <= cfg_data_i[psgc_pkg::DIMS_W-1:0];
        psgc_pkg::CFG_INTO_GRID: reg_into_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_busy_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == psgc_pkg::OP_START) begin
        req_busy_q <= !st_empty;
      end else if ((cmd_i.op == psgc_pkg::OP_EMIT) && last_q) begin
        req_busy_q <= 1'b0;
      end
      if (cmd_i.op == psgc_pkg::OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      psgc_pkg::OP_NONE: ;
      psgc_pkg::OP_START: begin
        contig_q   <= st_contig;
        lat_elem_q <= elem_c;
        lat_into_q <= reg_into_q;
        for (int i = 0; i < ND; i++) begin
          lat_grid_q[i]  <= st_grid[i];
          size_q[i]      <= st_size[i];
          off_neg_q[i]   <= st_neg[i];
          off_mag_q[i]   <= st_mag[i];
        end
        row_y_q   <= '0;
        row_z_q   <= '0;
        second_q  <= 1'b0;
        x_left_q  <= '0;
        buf_pos_q <= '0;
      end
      psgc_pkg::OP_DIV_LOAD: begin
        div_rem_q <= '0;
        div_num_q <= off_mag_q[cmd_i.dim];
      end
      psgc_pkg::OP_DIV_STEP: begin
        div_rem_q <= div_rem_next;
        div_num_q <= {div_num_q[EW-2:0], 1'b0};
      end
      psgc_pkg::OP_DIV_STORE: begin
        saved_off_q[cmd_i.dim] <= div_fix;
        if (cmd_i.dim == psgc_pkg::DIM_W'(1)) begin
          cur_y_q <= div_fix;
        end
        if (cmd_i.dim == psgc_pkg::DIM_W'(2)) begin
          cur_z_q <= div_fix;
        end
      end
      psgc_pkg::OP_CALC1: begin
        m1_q          <= M1_W'(c_zz) * M1_W'(lat_grid_q[1]);
        yy_q          <= c_yy;
        xx_q          <= c_xx;
        lb1_q         <= contig_q ? (LB1_W'(size_q[0]) * LB1_W'(size_q[1])) : LB1_W'(c_piece);
        xl_next_q     <= c_xl_next;
        second_next_q <= c_second_next;
        row_end_y_q   <= c_row_end_y;
        last_q        <= contig_q || (!c_second_next && c_row_end_y && c_row_end_z);
      end
      psgc_pkg::OP_CALC2: begin
        m2_q  <= M2_W'(M2_W'(m1_q) + M2_W'(yy_q)) * M2_W'(lat_grid_q[0]);
        lb2_q <= contig_q ? (LB2_W'(lb1_q) * LB2_W'(size_q[2])) : LB2_W'(lb1_q);
      end
      psgc_pkg::OP_CALC3: begin
        gofs_q <= gofs_full[psgc_pkg::OFS_W-1:0];
        len_q  <= len_full[psgc_pkg::LEN_W-1:0];
      end
      psgc_pkg::OP_EMIT: begin
        out_gofs_q <= gofs_q;
        out_bofs_q <= buf_pos_q[psgc_pkg::OFS_W-1:0];
        out_len_q  <= len_q;
        out_into_q <= lat_into_q;
        out_last_q <= last_q;
        buf_pos_q  <= buf_pos_next;
        if (!contig_q) begin
          x_left_q <= xl_next_q;
          second_q <= second_next_q;
          if (!second_next_q && !last_q) begin
            if (row_end_y_q) begin
              row_y_q <= '0;
              cur_y_q <= saved_off_q[1];
              row_z_q <= row_z_q + 1'b1;
              cur_z_q <= (cur_z_inc == {1'b0, lat_grid_q[2]}) ? '0 : cur_z_inc[EW-1:0];
            end else begin
              row_y_q <= row_y_q + 1'b1;
              cur_y_q <= (cur_y_inc == {1'b0, lat_grid_q[1]}) ? '0 : cur_y_inc[EW-1:0];
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign status_o.req_busy  = req_busy_q;
  assign status_o.out_stall = out_valid_q && !out_ready_i;

  assign out_valid_o          = out_valid_q;
  assign grid_byte_offset_o   = out_gofs_q;
  assign buffer_byte_offset_o = out_bofs_q;
  assign length_bytes_o       = out_len_q;
  assign write_to_grid_o      = out_into_q;
  assign last_o               = out_last_q;

endmodule

// File: rtl/periodic_subgrid_copy_address_gen_top.sv
// Segment address generator for copies between a periodic 3-D grid and a
// packed subgrid buffer.
// Channels: cfg (valid/ready, index + data, always ready) writes the grid
// extents, element size, dimension count and direction; it is sampled when a
// start beat is taken. The input channel carries start beats (action 0: offsets
// and sizes) and advance beats (action 1); each advance on an active request
// yields one beat on the output channel with grid offset, buffer offset,
// length, direction and a last flag. Advance beats while idle are dropped.
// Sequencing: a start beat wraps the three offsets through a shared
// bit-serial remainder unit, one bit per cycle, and the input stays busy
// until all three are stored. An advance runs the three-stage multiply chain
// for the grid offset; the next input beat is taken only after the result
// has been loaded into the output register.
// Stall: the result sits in an output register; the next advance is still
// taken and computed, and waits in its final stage until that register frees.
// Reset: registers return to their defaults and no request is active.
module periodic_subgrid_copy_address_gen_top #(
  parameter int MAX_EXTENT     = 1024,
  parameter int MAX_ELEM_BYTES = 16,
  parameter int MAX_DIMS       = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [psgc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [psgc_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                action_i,
  input  logic signed [psgc_pkg::EXT_W-1:0]   off_x_i,
  input  logic signed [psgc_pkg::EXT_W-1:0]   off_y_i,
  input  logic signed [psgc_pkg::EXT_W-1:0]   off_z_i,
  input  logic [psgc_pkg::EXT_W-1:0]          size_x_i,
  input  logic [psgc_pkg::EXT_W-1:0]          size_y_i,
  input  logic [psgc_pkg::EXT_W-1:0]          size_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [psgc_pkg::OFS_W-1:0]          grid_byte_offset_o,
  output logic [psgc_pkg::OFS_W-1:0]          buffer_byte_offset_o,
  output logic [psgc_pkg::LEN_W-1:0]          length_bytes_o,
  output logic                                write_to_grid_o,
  output logic                                last_o
);

  psgc_pkg::dp_cmd_t    cmd;
  psgc_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  psgc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  psgc_dp #(
    .MAX_EXTENT     (MAX_EXTENT),
    .MAX_ELEM_BYTES (MAX_ELEM_BYTES),
    .MAX_DIMS       (MAX_DIMS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .off_x_i              (off_x_i),
    .off_y_i              (off_y_i),
    .off_z_i              (off_z_i),
    .size_x_i             (size_x_i),
    .size_y_i             (size_y_i),
    .size_z_i             (size_z_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .grid_byte_offset_o   (grid_byte_offset_o),
    .buffer_byte_offset_o (buffer_byte_offset_o),
    .length_bytes_o       (length_bytes_o),
    .write_to_grid_o      (write_to_grid_o),
    .last_o               (last_o)
  );

endmodule

// File: rtl/psgc_checker.sv
module psgc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                action_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [psgc_pkg::OFS_W-1:0]          grid_byte_offset_o,
  input logic [psgc_pkg::OFS_W-1:0]          buffer_byte_offset_o,
  input logic [psgc_pkg::LEN_W-1:0]          length_bytes_o,
  input logic                                last_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(grid_byte_offset_o) &&
    $stable(buffer_byte_offset_o) && $stable(length_bytes_o) && $stable(last_o))
    else $error("result beat changed while stalled");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> length_bytes_o != '0)
    else $error("zero-length segment");

  // offset wrapping keeps the input busy after a start beat
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (action_i == psgc_pkg::ACT_START) |=> !in_ready_o)
    else $error("input ready right after start beat");

  // a new result is only loaded from the compute sequence
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without compute sequence");

endmodule

bind periodic_subgrid_copy_address_gen_top psgc_checker u_psgc_checker (.*);
